>>> hdl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

  localparam int WORD_W  = 16;
  localparam int WORD_LG = 4;
  localparam int FLD_W   = 11;
  localparam int IDX_W   = 12;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_ALLOC_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ALLOC_FAIL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FREED      = 2'd2;
  localparam logic [STAT_W-1:0] ST_FREE_BAD   = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [IDX_W-1:0]  base;
    logic [IDX_W-1:0]  run_in;
    logic [IDX_W-1:0]  len;
    logic [IDX_W-1:0]  size;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
  } word_eval_in_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  start;
    logic [IDX_W-1:0]  run_out;
    logic [WORD_W-1:0] mask;
  } word_eval_out_t;

endpackage

>>> hdl/ffba_ifs.sv
// Request and result channel interfaces of the first-fit block allocator.
interface ffba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [ffba_pkg::FLD_W-1:0]  req_length;
  logic [ffba_pkg::FLD_W-1:0]  free_start;
  logic [ffba_pkg::FLD_W-1:0]  free_length;

  modport source (output valid, output operation, output req_length,
                  output free_start, output free_length, input ready);
  modport sink (input valid, input operation, input req_length,
                input free_start, input free_length, output ready);
endinterface

interface ffba_res_if;
  logic                        valid;
  logic                        ready;
  logic [ffba_pkg::STAT_W-1:0] status;
  logic [ffba_pkg::FLD_W-1:0]  position;
  logic [ffba_pkg::FLD_W-1:0]  count;

  modport source (output valid, output status, output position, output count,
                  input ready);
  modport sink (input valid, input status, input position, input count,
                output ready);
endinterface

>>> hdl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: request sequencer around the bitmap.
//
//   channel   direction  beat contents
//   in_req    in         operation, req_length, free_start, free_length
//   out_res   out        status, position, count
//   cfg_*     in         pool_size write, no read-back
//
// After reset a clearing pass zeroes the bitmap, one 16-block word per cycle;
// no request is taken until it finishes. Allocate: one word per cycle is
// scanned, then the hit range is marked one word per cycle. Free: the range is
// checked and then cleared, one word per cycle each. One request is in work at
// a time; a held result does not block the next request until that request's
// own result is ready.
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [ffba_pkg::FLD_W-1:0] cfg_wr_data,
  ffba_req_if.sink                   in_req,
  ffba_res_if.source                 out_res
);

  localparam int DEPTH = (NUM_BLOCKS + ffba_pkg::WORD_W - 1) / ffba_pkg::WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP   = (NUM_BLOCKS > 2047) ? 2047 : NUM_BLOCKS;
  localparam logic [ffba_pkg::IDX_W-1:0] CAP_IDX  = ffba_pkg::IDX_W'(CAP);
  localparam logic [ffba_pkg::IDX_W-1:0] WORD_MSK = ~ffba_pkg::IDX_W'(ffba_pkg::WORD_W - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_MARK    = 3'd3;
  localparam logic [2:0] S_CHECK   = 3'd4;
  localparam logic [2:0] S_RELEASE = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [AW-1:0]               clr_addr_r, clr_addr_nxt;
  logic [ffba_pkg::FLD_W-1:0]  pool_r, pool_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [ffba_pkg::IDX_W-1:0]  len_r, len_nxt;
  logic [ffba_pkg::IDX_W-1:0]  lo_r, lo_nxt;
  logic [ffba_pkg::IDX_W-1:0]  hi_r, hi_nxt;
  logic [ffba_pkg::IDX_W-1:0]  issue_base_r, issue_base_nxt;
  logic [ffba_pkg::IDX_W-1:0]  last_base_r, last_base_nxt;
  logic [ffba_pkg::IDX_W-1:0]  rd_base_r, rd_base_nxt;
  logic [ffba_pkg::IDX_W-1:0]  run_r, run_nxt;
  logic [ffba_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [ffba_pkg::FLD_W-1:0]  res_pos_r, res_pos_nxt;
  logic [ffba_pkg::FLD_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic [ffba_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ffba_pkg::FLD_W-1:0]  out_pos_r, out_pos_nxt;
  logic [ffba_pkg::FLD_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [ffba_pkg::IDX_W-1:0]  size;
  logic                        mem_wr_en;
  logic [AW-1:0]               mem_wr_addr;
  logic [ffba_pkg::WORD_W-1:0] mem_wr_data;
  logic                        mem_rd_en;
  logic [ffba_pkg::WORD_W-1:0] mem_rd_data;

  ffba_pkg::word_eval_in_t     ev_in;
  ffba_pkg::word_eval_out_t    ev_out;

  ffba_bitmap_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (AW'(issue_base_r >> ffba_pkg::WORD_LG)),
    .rd_data (mem_rd_data)
  );

  ffba_word_eval u_eval (
    .ev_in  (ev_in),
    .ev_out (ev_out)
  );

  assign size = ({1'b0, pool_r} > CAP_IDX) ? CAP_IDX : {1'b0, pool_r};

  always_comb begin
    ev_in.data   = mem_rd_data;
    ev_in.base   = rd_base_r;
    ev_in.run_in = run_r;
    ev_in.len    = len_r;
    ev_in.size   = size;
    ev_in.lo     = lo_r;
    ev_in.hi     = hi_r;
  end

  assign in_req.ready     = (state_r == S_IDLE);
  assign out_res.valid    = out_valid_r;
  assign out_res.status   = out_status_r;
  assign out_res.position = out_pos_r;
  assign out_res.count    = out_cnt_r;

  always_comb begin
    logic                       stay;
    logic [ffba_pkg::IDX_W-1:0] fend;
    logic [ffba_pkg::IDX_W-1:0] alen;
    logic [ffba_pkg::IDX_W-1:0] flen;
    logic [ffba_pkg::IDX_W-1:0] fstart;
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    pool_nxt       = pool_r;
    rd_vld_nxt     = 1'b0;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    len_nxt        = len_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    issue_base_nxt = issue_base_r;
    last_base_nxt  = last_base_r;
    rd_base_nxt    = rd_base_r;
    run_nxt        = run_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_cnt_nxt    = res_cnt_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = AW'(rd_base_r >> ffba_pkg::WORD_LG);
    mem_wr_data    = '0;
    mem_rd_en      = 1'b0;
    stay           = 1'b0;
    alen           = {1'b0, in_req.req_length};
    flen           = {1'b0, in_req.free_length};
    fstart         = {1'b0, in_req.free_start};
    fend           = fstart + flen;

    if (cfg_wr_en) begin
      pool_nxt = cfg_wr_data;
    end

    case (state_r)
      S_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_req.valid) begin
          res_pos_nxt = '0;
          res_cnt_nxt = '0;
          state_nxt   = S_DONE;
          if (in_req.operation == ffba_pkg::OP_ALLOC) begin
            len_nxt = alen;
            if (alen == '0) begin
              res_status_nxt = ffba_pkg::ST_ALLOC_OK;
            end else if ((size == '0) || (alen > size)) begin
              res_status_nxt = ffba_pkg::ST_ALLOC_FAIL;
            end else begin
              issue_base_nxt = '0;
              last_base_nxt  = (size - 12'd1) & WORD_MSK;
              run_nxt        = '0;
              state_nxt      = S_SCAN;
            end
          end else begin
            if (fend > size) begin
              res_status_nxt = ffba_pkg::ST_FREE_BAD;
            end else if (flen == '0) begin
              res_status_nxt = ffba_pkg::ST_FREED;
              res_pos_nxt    = in_req.free_start;
            end else begin
              lo_nxt         = fstart;
              hi_nxt         = fend - 12'd1;
              issue_base_nxt = fstart & WORD_MSK;
              last_base_nxt  = (fend - 12'd1) & WORD_MSK;
              res_pos_nxt    = in_req.free_start;
              res_cnt_nxt    = in_req.free_length;
              state_nxt      = S_CHECK;
            end
          end
        end
      end
      S_SCAN: begin
        stay = 1'b1;
        if (rd_vld_r) begin
          run_nxt = ev_out.run_out;
          if (ev_out.hit) begin
            stay           = 1'b0;
            lo_nxt         = ev_out.start;
            hi_nxt         = ev_out.start + len_r - 12'd1;
            issue_base_nxt = ev_out.start & WORD_MSK;
            last_base_nxt  = (ev_out.start + len_r - 12'd1) & WORD_MSK;
            res_status_nxt = ffba_pkg::ST_ALLOC_OK;
            res_pos_nxt    = ev_out.start[ffba_pkg::FLD_W-1:0];
            res_cnt_nxt    = '0;
            state_nxt      = S_MARK;
          end else if (rd_base_r == last_base_r) begin
            stay           = 1'b0;
            res_status_nxt = ffba_pkg::ST_ALLOC_FAIL;
            res_pos_nxt    = '0;
            res_cnt_nxt    = '0;
            state_nxt      = S_DONE;
          end
        end
      end
      S_CHECK: begin
        stay = 1'b1;
        if (rd_vld_r) begin
          if ((ev_out.mask & ~mem_rd_data) != '0) begin
            stay           = 1'b0;
            res_status_nxt = ffba_pkg::ST_FREE_BAD;
            res_pos_nxt    = '0;
            res_cnt_nxt    = '0;
            state_nxt      = S_DONE;
          end else if (rd_base_r == last_base_r) begin
            // Every block is in use: go back over the range and clear it.
            stay           = 1'b0;
            issue_base_nxt = lo_r & WORD_MSK;
            res_status_nxt = ffba_pkg::ST_FREED;
            state_nxt      = S_RELEASE;
          end
        end
      end
      S_MARK, S_RELEASE: begin
        stay = 1'b1;
        if (rd_vld_r) begin
          mem_wr_en = 1'b1;
          if (state_r == S_MARK) begin
            mem_wr_data = mem_rd_data | ev_out.mask;
          end else begin
            mem_wr_data = mem_rd_data & ~ev_out.mask;
          end
          if (rd_base_r == last_base_r) begin
            stay      = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = res_pos_r;
          out_cnt_nxt    = res_cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Stream word reads while a scan, check or update pass stays active.
    if (stay && (issue_base_r <= last_base_r)) begin
      mem_rd_en      = 1'b1;
      rd_vld_nxt     = 1'b1;
      rd_base_nxt    = issue_base_r;
      issue_base_nxt = issue_base_r + ffba_pkg::IDX_W'(ffba_pkg::WORD_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      pool_r      <= 11'd1024;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pool_r      <= pool_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    issue_base_r <= issue_base_nxt;
    last_base_r  <= last_base_nxt;
    rd_base_r    <= rd_base_nxt;
    run_r        <= run_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_cnt_r    <= res_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

endmodule

>>> hdl/ffba_bitmap_ram.sv
// Occupancy bitmap memory: one write port, one registered read port.
module ffba_bitmap_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [ffba_pkg::WORD_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [ffba_pkg::WORD_W-1:0] rd_data
);

  logic [ffba_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/ffba_word_eval.sv
// Evaluates one bitmap word: first-fit hit, run carry and range mask.
module ffba_word_eval (
  input  ffba_pkg::word_eval_in_t  ev_in,
  output ffba_pkg::word_eval_out_t ev_out
);

  always_comb begin
    logic [ffba_pkg::IDX_W-1:0]   idx;
    logic [ffba_pkg::IDX_W-1:0]   run_b;
    logic [ffba_pkg::WORD_LG-1:0] last;
    logic                         seen;
    ev_out = '0;
    // Walk from the top bit down so the lowest hitting bit wins.
    for (int b = ffba_pkg::WORD_W - 1; b >= 0; b--) begin
      idx  = ev_in.base + ffba_pkg::IDX_W'(b);
      seen = 1'b0;
      last = '0;
      for (int k = 0; k <= b; k++) begin
        if (ev_in.data[k]) begin
          seen = 1'b1;
          last = ffba_pkg::WORD_LG'(k);
        end
      end
      if (seen) begin
        run_b = ffba_pkg::IDX_W'(b) - ffba_pkg::IDX_W'(last);
      end else begin
        run_b = ev_in.run_in + ffba_pkg::IDX_W'(b + 1);
      end
      if (!ev_in.data[b] && (idx < ev_in.size) && (run_b >= ev_in.len)) begin
        ev_out.hit   = 1'b1;
        ev_out.start = idx + 12'd1 - ev_in.len;
      end
      ev_out.mask[b] = (idx >= ev_in.lo) && (idx <= ev_in.hi);
    end

    seen = 1'b0;
    last = '0;
    for (int k = 0; k < ffba_pkg::WORD_W; k++) begin
      if (ev_in.data[k]) begin
        seen = 1'b1;
        last = ffba_pkg::WORD_LG'(k);
      end
    end
    if (seen) begin
      ev_out.run_out = ffba_pkg::IDX_W'(ffba_pkg::WORD_W - 1) - ffba_pkg::IDX_W'(last);
    end else begin
      ev_out.run_out = ev_in.run_in + ffba_pkg::IDX_W'(ffba_pkg::WORD_W);
    end
  end

endmodule
